@@ hdl/ffce_pkg.sv @@
// shared types, codes and helpers for the frame fill and copy engine
`default_nettype none

package ffce_pkg;

  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int COLOR_W = 4;
  localparam int CMD_W   = 2;
  localparam int MODE_W  = 2;
  // widest row * width + column sum for any legal geometry
  localparam int SUM_W   = X_W + Y_W + 1;

  localparam int DEFAULT_MAX_WIDTH  = 640;
  localparam int DEFAULT_MAX_HEIGHT = 480;

  localparam int DISP_W_WIDE   = 640;
  localparam int DISP_W_NARROW = 320;
  localparam int DISP_H_TALL   = 480;
  localparam int DISP_H_SHORT  = 200;

  typedef logic [X_W-1:0]     xcoord_t;
  typedef logic [Y_W-1:0]     ycoord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [MODE_W-1:0]  mode_t;

  localparam cmd_t CMD_PUT  = 2'd0;
  localparam cmd_t CMD_GET  = 2'd1;
  localparam cmd_t CMD_FILL = 2'd2;
  localparam cmd_t CMD_COPY = 2'd3;

  localparam mode_t MODE_640X480 = 2'd0;
  localparam mode_t MODE_640X200 = 2'd1;
  localparam mode_t MODE_320X200 = 2'd2;

  // active display size for the current mode
  typedef struct packed {
    xcoord_t disp_w;
    ycoord_t disp_h;
  } geom_t;

  // count of offsets from base that stay below limit, capped at len
  function automatic xcoord_t span(input xcoord_t base, input xcoord_t len,
                                   input xcoord_t limit);
    xcoord_t room;
    room = limit - base;
    if (base >= limit) begin
      span = '0;
    end else if (len < room) begin
      span = len;
    end else begin
      span = room;
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/ffce_frame_mem.sv @@
// frame store: one write port, one registered read port
`default_nettype none

module ffce_frame_mem #(
  parameter int MAX_WIDTH  = ffce_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ffce_pkg::DEFAULT_MAX_HEIGHT
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     waddr,
  input  wire ffce_pkg::color_t                            wdata,
  input  wire logic                                        re,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     raddr,
  output ffce_pkg::color_t                                 rdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  ffce_pkg::color_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ffce_addr_unit.sv @@
// shared address unit: row * display width + column
`default_nettype none

module ffce_addr_unit #(
  parameter int ADDR_W = 19
) (
  input  wire ffce_pkg::ycoord_t  row,
  input  wire ffce_pkg::xcoord_t  col,
  input  wire ffce_pkg::xcoord_t  disp_w,
  output logic [ADDR_W-1:0]       addr
);

  logic [ffce_pkg::SUM_W-1:0] sum;

  always_comb begin
    sum  = ffce_pkg::SUM_W'(row) * ffce_pkg::SUM_W'(disp_w) + ffce_pkg::SUM_W'(col);
    addr = sum[ADDR_W-1:0];
  end

endmodule

`default_nettype wire

@@ hdl/ffce_ctrl.sv @@
// command sequencer: clear pass, clipping, pixel walk and result register
`default_nettype none

module ffce_ctrl #(
  parameter int MAX_WIDTH  = ffce_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ffce_pkg::DEFAULT_MAX_HEIGHT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire ffce_pkg::cmd_t                          command,
  input  wire ffce_pkg::xcoord_t                       x_pos,
  input  wire ffce_pkg::ycoord_t                       y_pos,
  input  wire ffce_pkg::xcoord_t                       rect_width,
  input  wire ffce_pkg::ycoord_t                       rect_height,
  input  wire ffce_pkg::xcoord_t                       src_x,
  input  wire ffce_pkg::ycoord_t                       src_y,
  input  wire ffce_pkg::color_t                        color,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output ffce_pkg::color_t                             pixel_color,
  input  wire ffce_pkg::geom_t                         geom,
  output ffce_pkg::ycoord_t                            row,
  output ffce_pkg::xcoord_t                            col,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] addr,
  output logic                                         mem_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      mem_waddr,
  output ffce_pkg::color_t                             mem_wdata,
  output logic                                         mem_re,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      mem_raddr,
  input  wire ffce_pkg::color_t                        mem_rdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SIZE,
    S_PLACE,
    S_PUT,
    S_GET_RD,
    S_FILL,
    S_CP_RD,
    S_CP_WR,
    S_FINISH
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_cnt;

  ffce_pkg::cmd_t      cmd;
  ffce_pkg::xcoord_t   x0, x1, rw;
  ffce_pkg::ycoord_t   y0, y1, rh;
  ffce_pkg::color_t    fill_color;
  logic                back;
  logic                hit;
  ffce_pkg::xcoord_t   cw, last_x, cnt_x;
  ffce_pkg::ycoord_t   ch, cnt_y;
  ffce_pkg::xcoord_t   dcol, scol, dcol_first, scol_first;
  ffce_pkg::ycoord_t   drow, srow;

  ffce_pkg::xcoord_t   spx_d, spx_s;
  ffce_pkg::ycoord_t   spy_d, spy_s;
  ffce_pkg::xcoord_t   cw_m1;
  ffce_pkg::ycoord_t   ch_m1;

  ffce_pkg::xcoord_t   cnt_x_next, dcol_next, scol_next;
  ffce_pkg::ycoord_t   cnt_y_next, drow_next, srow_next;
  logic                walk_last;

  // clipped spans against the active display
  always_comb begin
    spx_d = ffce_pkg::span(x0, rw, geom.disp_w);
    spx_s = ffce_pkg::span(x1, rw, geom.disp_w);
    spy_d = ffce_pkg::ycoord_t'(ffce_pkg::span({1'b0, y0}, {1'b0, rh}, {1'b0, geom.disp_h}));
    spy_s = ffce_pkg::ycoord_t'(ffce_pkg::span({1'b0, y1}, {1'b0, rh}, {1'b0, geom.disp_h}));
    cw_m1 = cw - 10'd1;
    ch_m1 = ch - 9'd1;
  end

  // raster walk, forward or from bottom-right
  always_comb begin
    walk_last  = (cnt_x == '0) && (cnt_y == '0);
    cnt_x_next = cnt_x - 10'd1;
    cnt_y_next = cnt_y;
    dcol_next  = back ? dcol - 10'd1 : dcol + 10'd1;
    scol_next  = back ? scol - 10'd1 : scol + 10'd1;
    drow_next  = drow;
    srow_next  = srow;
    if (cnt_x == '0) begin
      cnt_x_next = last_x;
      cnt_y_next = cnt_y - 9'd1;
      dcol_next  = dcol_first;
      scol_next  = scol_first;
      drow_next  = back ? drow - 9'd1 : drow + 9'd1;
      srow_next  = back ? srow - 9'd1 : srow + 9'd1;
    end
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    row       = (state == S_CP_RD) ? srow : drow;
    col       = (state == S_CP_RD) ? scol : dcol;
    mem_we    = (state == S_CLEAR) || (state == S_PUT) || (state == S_FILL) ||
                (state == S_CP_WR);
    mem_waddr = (state == S_CLEAR) ? clr_cnt : addr;
    mem_wdata = (state == S_CLEAR) ? '0 :
                (state == S_CP_WR) ? mem_rdata : fill_color;
    mem_re    = (state == S_GET_RD) || (state == S_CP_RD);
    mem_raddr = addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            x0         <= x_pos;
            y0         <= y_pos;
            rw         <= rect_width;
            rh         <= rect_height;
            x1         <= src_x;
            y1         <= src_y;
            fill_color <= color;
            state      <= S_SIZE;
          end
        end
        S_SIZE: begin
          hit  <= 1'b0;
          back <= (cmd == ffce_pkg::CMD_COPY) && ((y0 > y1) || ((y0 == y1) && (x0 > x1)));
          case (cmd)
            ffce_pkg::CMD_PUT, ffce_pkg::CMD_GET: begin
              cw <= (x0 < geom.disp_w) ? 10'd1 : 10'd0;
              ch <= (y0 < geom.disp_h) ? 9'd1 : 9'd0;
            end
            ffce_pkg::CMD_FILL: begin
              cw <= spx_d;
              ch <= spy_d;
            end
            default: begin
              cw <= (spx_s < spx_d) ? spx_s : spx_d;
              ch <= (spy_s < spy_d) ? spy_s : spy_d;
            end
          endcase
          state <= S_PLACE;
        end
        S_PLACE: begin
          if ((cw == '0) || (ch == '0)) begin
            state <= S_FINISH;
          end else begin
            hit    <= 1'b1;
            cnt_x  <= cw_m1;
            last_x <= cw_m1;
            cnt_y  <= ch_m1;
            if (back) begin
              dcol       <= x0 + cw_m1;
              scol       <= x1 + cw_m1;
              dcol_first <= x0 + cw_m1;
              scol_first <= x1 + cw_m1;
              drow       <= y0 + ch_m1;
              srow       <= y1 + ch_m1;
            end else begin
              dcol       <= x0;
              scol       <= x1;
              dcol_first <= x0;
              scol_first <= x1;
              drow       <= y0;
              srow       <= y1;
            end
            case (cmd)
              ffce_pkg::CMD_PUT:  state <= S_PUT;
              ffce_pkg::CMD_GET:  state <= S_GET_RD;
              ffce_pkg::CMD_FILL: state <= S_FILL;
              default:            state <= S_CP_RD;
            endcase
          end
        end
        S_PUT: begin
          state <= S_FINISH;
        end
        S_GET_RD: begin
          state <= S_FINISH;
        end
        S_FILL, S_CP_WR: begin
          cnt_x <= cnt_x_next;
          cnt_y <= cnt_y_next;
          dcol  <= dcol_next;
          scol  <= scol_next;
          drow  <= drow_next;
          srow  <= srow_next;
          if (walk_last) begin
            state <= S_FINISH;
          end else if (state == S_CP_WR) begin
            state <= S_CP_RD;
          end
        end
        S_CP_RD: begin
          state <= S_CP_WR;
        end
        S_FINISH: begin
          // hold the result until the previous one is taken
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            pixel_color <= ((cmd == ffce_pkg::CMD_GET) && hit) ? mem_rdata : '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_write_in_display: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != S_CLEAR)) |-> ((dcol < geom.disp_w) && (drow < geom.disp_h)))
    else $error("pixel write outside the display");

  a_read_in_display: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> ((col < geom.disp_w) && (row < geom.disp_h)))
    else $error("pixel read outside the display");

  a_addr_in_store: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ({1'b0, mem_waddr} < (ADDR_W + 1)'(DEPTH)))
    else $error("write address beyond the frame store");

  a_copy_read_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_CP_WR) |-> ($past(state) == S_CP_RD))
    else $error("copy write without a source read");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer ready right after taking a request");

endmodule

`default_nettype wire

@@ hdl/frame_fill_copy_engine.sv @@
// fill: one pixel per cycle
// copy: each pixel is a frame store read then a write on its single ports
// one request at a time; the next is taken while an earlier result still waits
// reset: mode 640x480, then a clear pass over all MAX_WIDTH*MAX_HEIGHT pixels (307200 by default)
// zeroes the frame store, one pixel a cycle, with no request taken; mode writes always taken
`default_nettype none

module frame_fill_copy_engine #(
  parameter int MAX_WIDTH  = ffce_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ffce_pkg::DEFAULT_MAX_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire ffce_pkg::mode_t    cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ffce_pkg::cmd_t     command,
  input  wire ffce_pkg::xcoord_t  x_pos,
  input  wire ffce_pkg::ycoord_t  y_pos,
  input  wire ffce_pkg::xcoord_t  rect_width,
  input  wire ffce_pkg::ycoord_t  rect_height,
  input  wire ffce_pkg::xcoord_t  src_x,
  input  wire ffce_pkg::ycoord_t  src_y,
  input  wire ffce_pkg::color_t   color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffce_pkg::color_t        pixel_color,
  output logic                    done_res
);

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

  localparam int W_WIDE   = (ffce_pkg::DISP_W_WIDE > MAX_WIDTH) ?
                            MAX_WIDTH : ffce_pkg::DISP_W_WIDE;
  localparam int W_NARROW = (ffce_pkg::DISP_W_NARROW > MAX_WIDTH) ?
                            MAX_WIDTH : ffce_pkg::DISP_W_NARROW;
  localparam int H_TALL   = (ffce_pkg::DISP_H_TALL > MAX_HEIGHT) ?
                            MAX_HEIGHT : ffce_pkg::DISP_H_TALL;
  localparam int H_SHORT  = (ffce_pkg::DISP_H_SHORT > MAX_HEIGHT) ?
                            MAX_HEIGHT : ffce_pkg::DISP_H_SHORT;

  ffce_pkg::mode_t     display_mode;
  ffce_pkg::geom_t     geom;
  ffce_pkg::ycoord_t   row;
  ffce_pkg::xcoord_t   col;
  logic [ADDR_W-1:0]   addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  ffce_pkg::color_t    mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  ffce_pkg::color_t    mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= ffce_pkg::MODE_640X480;
    end else if (cfg_valid && cfg_ready) begin
      display_mode <= cfg_data;
    end
  end

  // unused mode code falls back to the full display
  always_comb begin
    cfg_ready   = 1'b1;
    done_res    = 1'b1;
    geom.disp_w = (display_mode == ffce_pkg::MODE_320X200) ?
                  ffce_pkg::xcoord_t'(W_NARROW) : ffce_pkg::xcoord_t'(W_WIDE);
    geom.disp_h = ((display_mode == ffce_pkg::MODE_640X200) ||
                   (display_mode == ffce_pkg::MODE_320X200)) ?
                  ffce_pkg::ycoord_t'(H_SHORT) : ffce_pkg::ycoord_t'(H_TALL);
  end

  ffce_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .src_x       (src_x),
    .src_y       (src_y),
    .color       (color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_color (pixel_color),
    .geom        (geom),
    .row         (row),
    .col         (col),
    .addr        (addr),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  ffce_addr_unit #(
    .ADDR_W (ADDR_W)
  ) u_addr (
    .row    (row),
    .col    (col),
    .disp_w (geom.disp_w),
    .addr   (addr)
  );

  ffce_frame_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_frame_fill_copy_engine.sv @@
// self-checking bench for the frame fill and copy engine: draw commands against a frame model
module tb_frame_fill_copy_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ffce_pkg::*;

  localparam int FRAME_PIXELS    = DEFAULT_MAX_WIDTH * DEFAULT_MAX_HEIGHT;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 203;
  // quiet limit is longer than the clear pass and than a worst unclipped copy
  localparam int unsigned QUIET_LIMIT = 2_000_000;
  // mode code the block does not define; it behaves as 640x480
  localparam mode_t MODE_UNUSED = 2'd3;

  typedef struct {
    cmd_t    command;
    xcoord_t x_pos;
    ycoord_t y_pos;
    xcoord_t rect_width;
    ycoord_t rect_height;
    xcoord_t src_x;
    ycoord_t src_y;
    color_t  color;
    bit      drain_first;
  } draw_req_t;

  typedef struct {
    color_t pixel_color;
    logic   done_res;
  } completion_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  mode_t   cfg_data = MODE_640X480;
  logic    in_valid = 1'b0;
  logic    in_ready;
  cmd_t    command = CMD_PUT;
  xcoord_t x_pos = '0;
  ycoord_t y_pos = '0;
  xcoord_t rect_width = '0;
  ycoord_t rect_height = '0;
  xcoord_t src_x = '0;
  ycoord_t src_y = '0;
  color_t  color = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  color_t  pixel_color;
  logic    done_res;

  bit [COLOR_W-1:0] frame_model [FRAME_PIXELS];
  mode_t            mode_model = MODE_640X480;

  draw_req_t   queued_requests[$];
  completion_t completions_due[$];
  draw_req_t   req_on_bus;
  int unsigned requests_taken  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  int unsigned hot_x = 0, hot_y = 0;

  always #5 clk = ~clk;

  frame_fill_copy_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .src_x       (src_x),
    .src_y       (src_y),
    .color       (color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_color (pixel_color),
    .done_res    (done_res)
  );

  function automatic int unsigned width_of(mode_t m);
    return (m == MODE_320X200) ? DISP_W_NARROW : DISP_W_WIDE;
  endfunction

  function automatic int unsigned height_of(mode_t m);
    return (m == MODE_640X200 || m == MODE_320X200) ? DISP_H_SHORT : DISP_H_TALL;
  endfunction

  // pixels from base up to len that stay inside [0, limit)
  function automatic int unsigned clip_len(int unsigned base, int unsigned len,
                                           int unsigned limit);
    if (base >= limit) return 0;
    return (len < limit - base) ? len : limit - base;
  endfunction

  // updates the frame model and returns the color a get would read
  function automatic color_t apply_draw_command(draw_req_t r);
    int unsigned dw, dh, cw, ch, x0, y0, x1, y1;
    int x, y;
    color_t pix;
    dw  = width_of(mode_model);
    dh  = height_of(mode_model);
    x0  = r.x_pos;
    y0  = r.y_pos;
    x1  = r.src_x;
    y1  = r.src_y;
    pix = '0;
    case (r.command)
      CMD_PUT: begin
        if (x0 < dw && y0 < dh) frame_model[y0 * dw + x0] = r.color;
      end
      CMD_GET: begin
        if (x0 < dw && y0 < dh) pix = frame_model[y0 * dw + x0];
      end
      CMD_FILL: begin
        cw = clip_len(x0, r.rect_width, dw);
        ch = clip_len(y0, r.rect_height, dh);
        for (y = 0; y < ch; y++)
          for (x = 0; x < cw; x++) frame_model[(y0 + y) * dw + x0 + x] = r.color;
      end
      default: begin
        cw = clip_len(x0, r.rect_width, dw);
        if (clip_len(x1, r.rect_width, dw) < cw) cw = clip_len(x1, r.rect_width, dw);
        ch = clip_len(y0, r.rect_height, dh);
        if (clip_len(y1, r.rect_height, dh) < ch) ch = clip_len(y1, r.rect_height, dh);
        if (y0 > y1 || (y0 == y1 && x0 > x1)) begin
          // destination later in raster order: walk from the bottom-right pixel
          for (y = ch; y > 0; y--)
            for (x = cw; x > 0; x--)
              frame_model[(y0 + y - 1) * dw + x0 + x - 1] =
                frame_model[(y1 + y - 1) * dw + x1 + x - 1];
        end else begin
          for (y = 0; y < ch; y++)
            for (x = 0; x < cw; x++)
              frame_model[(y0 + y) * dw + x0 + x] = frame_model[(y1 + y) * dw + x1 + x];
        end
      end
    endcase
    return pix;
  endfunction

  function automatic int unsigned jitter(int unsigned base, int unsigned top);
    int unsigned v;
    v = base + $urandom_range(23);
    return (v > top) ? top : v;
  endfunction

  // most requests land in small windows so reads and copies see earlier writes
  function automatic draw_req_t random_request();
    draw_req_t r;
    int unsigned dw, dh, pick, bx, by;
    dw   = width_of(mode_model);
    dh   = height_of(mode_model);
    pick = $urandom_range(99);
    if (pick < 30) begin
      bx = 0;
      by = 0;
    end else if (pick < 60) begin
      bx = dw - 16;
      by = dh - 16;
    end else if (pick < 85) begin
      bx = hot_x;
      by = hot_y;
    end else begin
      bx = $urandom_range(639);
      by = $urandom_range(479);
    end
    pick = $urandom_range(99);
    if (pick < 30) r.command = CMD_PUT;
    else if (pick < 60) r.command = CMD_GET;
    else if (pick < 78) r.command = CMD_FILL;
    else r.command = CMD_COPY;
    r.x_pos = xcoord_t'(jitter(bx, 639));
    r.y_pos = ycoord_t'(jitter(by, 479));
    if ($urandom_range(99) < 20) begin
      r.src_x = xcoord_t'($urandom_range(639));
      r.src_y = ycoord_t'($urandom_range(479));
    end else begin
      r.src_x = xcoord_t'(jitter(bx, 639));
      r.src_y = ycoord_t'(jitter(by, 479));
    end
    pick = $urandom_range(99);
    if (pick < 85) begin
      r.rect_width  = xcoord_t'($urandom_range(8));
      r.rect_height = ycoord_t'($urandom_range(8));
    end else if (pick < 95) begin
      r.rect_width  = xcoord_t'($urandom_range(40));
      r.rect_height = ycoord_t'($urandom_range(24));
    end else begin
      // huge sizes, but anchored at the last columns and rows so little gets drawn
      r.rect_width  = xcoord_t'($urandom_range(640));
      r.rect_height = ycoord_t'($urandom_range(480));
      r.x_pos       = xcoord_t'($urandom_range(639, dw - 3));
      r.y_pos       = ycoord_t'($urandom_range(479, dh - 3));
    end
    r.color       = color_t'($urandom_range(15));
    r.drain_first = ($urandom_range(99) < 2);
    return r;
  endfunction

  task automatic queue_request(cmd_t cmd, int unsigned x, int unsigned y, int unsigned w,
                               int unsigned h, int unsigned sx, int unsigned sy,
                               int unsigned col);
    draw_req_t r;
    r.command     = cmd;
    r.x_pos       = xcoord_t'(x);
    r.y_pos       = ycoord_t'(y);
    r.rect_width  = xcoord_t'(w);
    r.rect_height = ycoord_t'(h);
    r.src_x       = xcoord_t'(sx);
    r.src_y       = ycoord_t'(sy);
    r.color       = color_t'(col);
    r.drain_first = 1'b0;
    queued_requests.push_back(r);
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || completions_due.size() != 0);
  endtask

  task automatic write_mode(mode_t m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk);
    while (!cfg_ready);
    mode_model = m;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : request_driver
    completion_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.pixel_color = apply_draw_command(req_on_bus);
        c.done_res    = 1'b1;
        completions_due.push_back(c);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!queued_requests[0].drain_first || requests_taken == results_checked)) begin
          req_on_bus = queued_requests.pop_front();
          command     <= req_on_bus.command;
          x_pos       <= req_on_bus.x_pos;
          y_pos       <= req_on_bus.y_pos;
          rect_width  <= req_on_bus.rect_width;
          rect_height <= req_on_bus.rect_height;
          src_x       <= req_on_bus.src_x;
          src_y       <= req_on_bus.src_y;
          color       <= req_on_bus.color;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    completion_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        results_checked <= results_checked + 1;
        if (completions_due.size() == 0) begin
          $error("result with no request outstanding: pixel_color %0d done_res %0b",
                 pixel_color, done_res);
          mismatches++;
        end else begin
          want = completions_due.pop_front();
          if (pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %0d, actual %0d", want.pixel_color, pixel_color);
            mismatches++;
          end
          if (done_res !== want.done_res) begin
            $error("done_res: expected %0b, actual %0b", want.done_res, done_res);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_mode(MODE_640X480);

    // corners, clipping, empty rectangles and both copy directions
    queue_request(CMD_PUT, 0, 0, 0, 0, 0, 0, 15);
    queue_request(CMD_PUT, 639, 479, 0, 0, 0, 0, 10);
    queue_request(CMD_GET, 0, 0, 0, 0, 0, 0, 0);
    queue_request(CMD_GET, 639, 479, 0, 0, 0, 0, 0);
    queue_request(CMD_GET, 1, 0, 0, 0, 0, 0, 0);
    queue_request(CMD_FILL, 10, 5, 4, 3, 0, 0, 5);
    queue_request(CMD_GET, 12, 6, 0, 0, 0, 0, 0);
    queue_request(CMD_FILL, 639, 479, 640, 480, 0, 0, 3);
    queue_request(CMD_GET, 639, 479, 0, 0, 0, 0, 0);
    queue_request(CMD_FILL, 10, 5, 0, 5, 0, 0, 9);
    queue_request(CMD_FILL, 10, 5, 5, 0, 0, 0, 9);
    queue_request(CMD_COPY, 8, 4, 6, 5, 10, 5, 0);
    queue_request(CMD_COPY, 11, 6, 6, 5, 8, 4, 0);
    queue_request(CMD_COPY, 10, 4, 5, 2, 8, 4, 0);
    queue_request(CMD_COPY, 10, 10, 20, 20, 630, 470, 0);
    queue_request(CMD_COPY, 0, 0, 640, 480, 639, 479, 0);
    queue_request(CMD_COPY, 3, 3, 0, 4, 0, 0, 0);
    queue_request(CMD_GET, 12, 7, 0, 0, 0, 0, 0);
    wait_quiet();
    write_mode(MODE_320X200);
    queue_request(CMD_PUT, 320, 0, 0, 0, 0, 0, 4);
    queue_request(CMD_GET, 320, 0, 0, 0, 0, 0, 0);
    queue_request(CMD_PUT, 0, 200, 0, 0, 0, 0, 4);
    queue_request(CMD_FILL, 0, 0, 640, 480, 0, 0, 7);
    queue_request(CMD_GET, 319, 199, 0, 0, 0, 0, 0);
    queue_request(CMD_COPY, 0, 0, 640, 480, 1, 0, 0);
    queue_request(CMD_GET, 318, 199, 0, 0, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      case (p)
        0, 4, 7: write_mode(MODE_320X200);
        1, 5:    write_mode(MODE_640X200);
        2:       write_mode(MODE_UNUSED);
        default: write_mode(MODE_640X480);
      endcase
      hot_x = $urandom_range(width_of(mode_model) - 1);
      hot_y = $urandom_range(height_of(mode_model) - 1);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 74;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 74;
        end
        default: begin
          send_idle_pct = 22;
          stall_pct     = 22;
        end
      endcase
      repeat (ITEMS_PER_PHASE) queued_requests.push_back(random_request());
    end

    wait_quiet();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
